// ===== rtl/core/ptd_pkg.sv =====
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types, codes and constants of the periodic timer dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package ptd_pkg;

  localparam int SLOT_COUNT_DEF = 8;
  localparam int RING_DEPTH_DEF = 8192;

  localparam logic [31:0] TICK_RATE_RESET = 32'd100;
  // 2^72 / 15625 rounded up: x / 15625 is (x * US_RECIP) >> 72 for x below 2^58
  localparam logic [63:0] US_RECIP        = 64'd302231454903657294;
  localparam logic [19:0] CLAMP_US        = 20'd1000000;

  localparam logic [2:0] KIND_REGISTER   = 3'd0;
  localparam logic [2:0] KIND_UNREGISTER = 3'd1;
  localparam logic [2:0] KIND_TICK       = 3'd2;
  localparam logic [2:0] KIND_ARM        = 3'd3;
  localparam logic [2:0] KIND_DISARM     = 3'd4;
  localparam logic [2:0] KIND_READ       = 3'd5;

  localparam logic [1:0] RK_STATUS = 2'd0;
  localparam logic [1:0] RK_FIRE   = 2'd1;
  localparam logic [1:0] RK_SAMPLE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NO_SAMPLE = 3'd4;

  localparam logic REG_TICK_RATE = 1'b0;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] callback_id;
    logic [31:0] interval_us;
    logic [63:0] tick_count;
    logic [63:0] now_us;
    logic [12:0] sample_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [2:0]  status;
    logic [2:0]  slot;
    logic [15:0] fired_id;
    logic [63:0] sequence_res;
    logic [19:0] lateness_us;
    logic [13:0] sample_count;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [31:0] interval_us;
    logic [63:0] interval_ticks;
    logic [63:0] due_tick;
    logic [63:0] last_us;
  } slot_rec_t;

  typedef struct packed {
    logic        arm;
    logic        push;
    logic [19:0] push_data;
    logic        rd;
    logic [12:0] rd_index;
  } ring_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_REG_DIV,
    S_REG_WR,
    S_TK_RD,
    S_TK_EVA,
    S_TK_EVB,
    S_TK_END,
    S_RD_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/ptd_div.sv =====
// ----------------------------------------------------------------------------
// ptd_div
// Divide by one million: shift by six, then reciprocal multiply by 1/15625
// as four 32x32 partial products accumulated in sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  output logic             done,
  output logic [63:0]      quotient
);

  localparam logic [63:0] RECIP = ptd_pkg::US_RECIP;

  logic [57:0]  xs;
  logic [127:0] acc;
  logic [1:0]   step;
  logic         running;
  logic [31:0]  op_x;
  logic [31:0]  op_m;
  logic [63:0]  prod;
  logic [127:0] addend;

  always_comb begin
    op_x = step[1] ? {6'b0, xs[57:32]} : xs[31:0];
    op_m = step[0] ? RECIP[63:32] : RECIP[31:0];
    prod = 64'(op_x) * 64'(op_m);
    case (step)
      2'd0: begin
        addend = {64'b0, prod};
      end
      2'd3: begin
        addend = {prod, 64'b0};
      end
      default: begin
        addend = {32'b0, prod, 32'b0};
      end
    endcase
  end

  assign quotient = {8'b0, acc[127:72]};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && step == 2'd3) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs   <= dividend[63:6];
      acc  <= '0;
      step <= '0;
    end else if (running) begin
      acc  <= acc + addend;
      step <= step + 2'd1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ptd_ring.sv =====
// ----------------------------------------------------------------------------
// ptd_ring
// Lateness sample ring: head, fill count, sample memory and index lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_ring #(
  parameter int DEPTH = ptd_pkg::RING_DEPTH_DEF,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ptd_pkg::ring_cmd_t   cmd,
  output logic [CW-1:0]             fill,
  output logic                      hit,
  output logic [19:0]               rd_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int IW = 13;
  localparam int SW = ((AW > IW) ? AW : IW) + 1;

  logic [19:0]   mem [DEPTH];
  logic [AW-1:0] head;
  logic [AW-1:0] start_q;
  logic [AW:0]   start_c;
  logic [AW:0]   head_x;
  logic [AW:0]   fill_x;
  logic [SW-1:0] sum;
  logic [SW-1:0] pos;

  assign head_x = {1'b0, head};
  assign fill_x = (AW + 1)'(fill);

  always_comb begin
    if (head_x >= fill_x) begin
      start_c = head_x - fill_x;
    end else begin
      start_c = head_x + (AW + 1)'(DEPTH) - fill_x;
    end
    sum = SW'(start_q) + SW'(cmd.rd_index);
    if (sum >= SW'(DEPTH)) begin
      pos = sum - SW'(DEPTH);
    end else begin
      pos = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else if (cmd.arm) begin
      head <= '0;
      fill <= '0;
    end else if (cmd.push) begin
      head <= (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
      if (fill != CW'(DEPTH)) begin
        fill <= fill + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    start_q <= start_c[AW-1:0];
    if (cmd.push) begin
      mem[head] <= cmd.push_data;
    end
    if (cmd.rd) begin
      rd_data <= mem[pos[AW-1:0]];
      hit     <= SW'(cmd.rd_index) < SW'(fill);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/periodic_timer_dispatcher.sv =====
// ----------------------------------------------------------------------------
// periodic_timer_dispatcher
// Multi-slot periodic timer with fire sequencing and lateness recording.
// ----------------------------------------------------------------------------
// Sequencing: a register that claims a slot runs the reciprocal divide by one
//   million in four steps before it writes the slot. A tick holds busy while
//   it walks every slot; its last fire result is the one flagged last.
// Throughput: one request at a time, busy high until its last result.
// Reset: synchronous; slots inactive, counters zero, tick rate 100 Hz.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_dispatcher #(
  parameter int SLOT_COUNT = ptd_pkg::SLOT_COUNT_DEF,
  parameter int RING_DEPTH = ptd_pkg::RING_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire ptd_pkg::req_t req,
  output logic               result_valid,
  output ptd_pkg::res_t      result,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(RING_DEPTH + 1);

  ptd_pkg::state_t    state;
  ptd_pkg::state_t    state_next;
  ptd_pkg::req_t      req_q;
  ptd_pkg::slot_rec_t slot_mem [SLOT_COUNT];
  ptd_pkg::slot_rec_t mem_rd;
  ptd_pkg::slot_rec_t mem_wdata;
  ptd_pkg::res_t      emit_res;
  ptd_pkg::res_t      fire_res;
  ptd_pkg::res_t      pend;
  ptd_pkg::ring_cmd_t ring_cmd;

  logic [31:0]           tick_rate;
  logic [SLOT_COUNT-1:0] active;
  logic [15:0]           client [SLOT_COUNT];
  logic [SW-1:0]         cnt;
  logic [SW-1:0]         reg_slot;
  logic [SW-1:0]         free_idx;
  logic [SW-1:0]         mem_addr;
  logic                  free_found;
  logic                  dup;
  logic                  reg_bad;
  logic                  reg_go;
  logic                  cnt_last;
  logic [63:0]           last_tick;
  logic [63:0]           fire_counter;
  logic                  jit_en;
  logic                  pend_valid;
  logic                  emit;
  logic                  mem_we;
  logic                  mem_re;
  logic                  div_start;
  logic                  div_done;
  logic [63:0]           div_q;
  logic [63:0]           ticks;
  logic                  due;
  logic [63:0]           nd1;
  logic [63:0]           nd2;
  logic [63:0]           actual;
  logic [63:0]           nd;
  logic [63:0]           diff;
  logic [19:0]           late;
  logic [CW-1:0]         ring_fill;
  logic                  ring_hit;
  logic [19:0]           ring_data;
  logic                  cfg_write;

  assign busy      = state != ptd_pkg::S_IDLE;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == ptd_pkg::REG_TICK_RATE) ? tick_rate : '0;
  assign cnt_last  = cnt == SW'(SLOT_COUNT - 1);
  assign reg_bad   = req_q.callback_id == '0 || req_q.interval_us == '0;
  assign reg_go    = !reg_bad && !dup && free_found;
  assign due       = req_q.tick_count >= mem_rd.due_tick;

  ptd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (64'(req_q.interval_us) * 64'(tick_rate)),
    .done     (div_done),
    .quotient (div_q)
  );

  ptd_ring #(
    .DEPTH (RING_DEPTH),
    .CW    (CW)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .cmd     (ring_cmd),
    .fill    (ring_fill),
    .hit     (ring_hit),
    .rd_data (ring_data)
  );

  always_comb begin
    dup        = 1'b0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (active[i] && client[i] == req_q.callback_id) begin
        dup = 1'b1;
      end
      if (!active[i] && !free_found) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  // fire arithmetic on the registered slot read
  always_comb begin
    nd   = (nd1 <= req_q.tick_count) ? nd2 : nd1;
    diff = actual - 64'(mem_rd.interval_us);
    if (actual <= 64'(mem_rd.interval_us)) begin
      late = '0;
    end else if (diff > 64'(ptd_pkg::CLAMP_US)) begin
      late = ptd_pkg::CLAMP_US;
    end else begin
      late = diff[19:0];
    end
    ticks = (div_q == '0) ? 64'd1 : div_q;
    fire_res              = '0;
    fire_res.result_kind  = ptd_pkg::RK_FIRE;
    fire_res.status       = ptd_pkg::ST_OK;
    fire_res.slot         = 3'(cnt);
    fire_res.fired_id     = client[cnt];
    fire_res.sequence_res = fire_counter + 64'd1;
    fire_res.lateness_us  = jit_en ? late : '0;
  end

  always_comb begin
    state_next = state;
    case (state)
      ptd_pkg::S_IDLE: begin
        if (start) begin
          state_next = ptd_pkg::S_DISPATCH;
        end
      end
      ptd_pkg::S_DISPATCH: begin
        if (req_q.kind == ptd_pkg::KIND_REGISTER && reg_go) begin
          state_next = ptd_pkg::S_REG_DIV;
        end else if (req_q.kind == ptd_pkg::KIND_TICK) begin
          state_next = ptd_pkg::S_TK_RD;
        end else if (req_q.kind == ptd_pkg::KIND_READ) begin
          state_next = ptd_pkg::S_RD_OUT;
        end else begin
          state_next = ptd_pkg::S_IDLE;
        end
      end
      ptd_pkg::S_REG_DIV: begin
        if (div_done) begin
          state_next = ptd_pkg::S_REG_WR;
        end
      end
      ptd_pkg::S_TK_RD: begin
        if (active[cnt]) begin
          state_next = ptd_pkg::S_TK_EVA;
        end else if (cnt_last) begin
          state_next = ptd_pkg::S_TK_END;
        end
      end
      ptd_pkg::S_TK_EVA: begin
        if (due) begin
          state_next = ptd_pkg::S_TK_EVB;
        end else if (cnt_last) begin
          state_next = ptd_pkg::S_TK_END;
        end else begin
          state_next = ptd_pkg::S_TK_RD;
        end
      end
      ptd_pkg::S_TK_EVB: begin
        state_next = cnt_last ? ptd_pkg::S_TK_END : ptd_pkg::S_TK_RD;
      end
      default: begin
        state_next = ptd_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    emit      = 1'b0;
    emit_res  = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = cnt;
    mem_wdata = mem_rd;
    ring_cmd  = '0;
    div_start = 1'b0;
    emit_res.last = 1'b1;
    case (state)
      ptd_pkg::S_DISPATCH: begin
        case (req_q.kind)
          ptd_pkg::KIND_REGISTER: begin
            emit = !reg_go;
            if (reg_bad) begin
              emit_res.status = ptd_pkg::ST_INVALID;
            end else if (dup) begin
              emit_res.status = ptd_pkg::ST_DUPLICATE;
            end else begin
              emit_res.status = ptd_pkg::ST_FULL;
            end
            div_start = reg_go;
          end
          ptd_pkg::KIND_UNREGISTER: begin
            emit = 1'b1;
            emit_res.status = (req_q.callback_id == '0) ? ptd_pkg::ST_INVALID
                                                        : ptd_pkg::ST_OK;
          end
          ptd_pkg::KIND_TICK: begin
            emit = 1'b0;
          end
          ptd_pkg::KIND_ARM: begin
            emit         = 1'b1;
            ring_cmd.arm = 1'b1;
          end
          ptd_pkg::KIND_DISARM: begin
            emit = 1'b1;
          end
          ptd_pkg::KIND_READ: begin
            ring_cmd.rd       = 1'b1;
            ring_cmd.rd_index = req_q.sample_index;
          end
          default: begin
            emit            = 1'b1;
            emit_res.status = ptd_pkg::ST_INVALID;
          end
        endcase
      end
      ptd_pkg::S_REG_WR: begin
        mem_we                   = 1'b1;
        mem_addr                 = reg_slot;
        mem_wdata.interval_us    = req_q.interval_us;
        mem_wdata.interval_ticks = ticks;
        mem_wdata.due_tick       = last_tick + ticks;
        mem_wdata.last_us        = req_q.now_us;
        emit                     = 1'b1;
        emit_res.slot            = 3'(reg_slot);
      end
      ptd_pkg::S_TK_RD: begin
        mem_re = active[cnt];
      end
      ptd_pkg::S_TK_EVB: begin
        mem_we             = 1'b1;
        mem_wdata.due_tick = nd;
        if (jit_en) begin
          mem_wdata.last_us  = req_q.now_us;
          ring_cmd.push      = 1'b1;
          ring_cmd.push_data = late;
        end
        emit          = pend_valid;
        emit_res      = pend;
        emit_res.last = 1'b0;
      end
      ptd_pkg::S_TK_END: begin
        emit          = pend_valid;
        emit_res      = pend;
        emit_res.last = 1'b1;
      end
      ptd_pkg::S_RD_OUT: begin
        emit                  = 1'b1;
        emit_res.result_kind  = ptd_pkg::RK_SAMPLE;
        emit_res.status       = ring_hit ? ptd_pkg::ST_OK : ptd_pkg::ST_NO_SAMPLE;
        emit_res.lateness_us  = ring_hit ? ring_data : '0;
        emit_res.sample_count = 14'(ring_fill);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ptd_pkg::S_IDLE;
      tick_rate    <= ptd_pkg::TICK_RATE_RESET;
      active       <= '0;
      last_tick    <= '0;
      fire_counter <= '0;
      jit_en       <= 1'b0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= emit;
      if (cfg_write && paddr[2] == ptd_pkg::REG_TICK_RATE && pwdata != '0) begin
        tick_rate <= pwdata;
      end
      if (state == ptd_pkg::S_DISPATCH) begin
        case (req_q.kind)
          ptd_pkg::KIND_UNREGISTER: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (req_q.callback_id != '0 && client[i] == req_q.callback_id) begin
                active[i] <= 1'b0;
              end
            end
          end
          ptd_pkg::KIND_TICK: begin
            last_tick <= req_q.tick_count;
          end
          ptd_pkg::KIND_ARM: begin
            jit_en <= 1'b1;
          end
          ptd_pkg::KIND_DISARM: begin
            jit_en <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (state == ptd_pkg::S_REG_WR) begin
        active[reg_slot] <= 1'b1;
      end
      if (state == ptd_pkg::S_TK_EVB) begin
        fire_counter <= fire_counter + 64'd1;
        pend_valid   <= 1'b1;
      end
      if (state == ptd_pkg::S_TK_END) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= emit_res;
    if (start && !busy) begin
      req_q <= req;
    end
    if (state == ptd_pkg::S_DISPATCH) begin
      reg_slot <= free_idx;
      cnt      <= '0;
    end else if (state_next == ptd_pkg::S_TK_RD) begin
      cnt <= cnt + SW'(1);
    end
    if (state == ptd_pkg::S_REG_WR) begin
      client[reg_slot] <= req_q.callback_id;
    end
    if (state == ptd_pkg::S_TK_EVA) begin
      nd1    <= mem_rd.due_tick + mem_rd.interval_ticks;
      nd2    <= req_q.tick_count + mem_rd.interval_ticks;
      actual <= req_q.now_us - mem_rd.last_us;
    end
    if (state == ptd_pkg::S_TK_EVB) begin
      pend <= fire_res;
    end
  end

  // slot memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rd <= slot_mem[mem_addr];
    end
  end

  a_result_in_request: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result outside a request");

  a_last_then_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |=> !result_valid)
    else $error("result after final result");

  // a fire leaves one slot behind, so the counter may already be one ahead
  a_fire_sequence: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_kind == ptd_pkg::RK_FIRE |->
      (result.sequence_res == fire_counter ||
       result.sequence_res + 64'd1 == fire_counter))
    else $error("fire sequence mismatch");

endmodule

`default_nettype wire
